// ----- hdl/npcs_pkg.sv -----
// Shared types and constants for the nearest palette color search block.
package npcs_pkg;

  // Field widths of the stream words and the count register
  localparam int COLOR_W = 8;
  localparam int ENTRY_W = 8;
  localparam int CNT_W   = 9;

  // Distance arithmetic widths
  localparam int SQ_W   = 2 * COLOR_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int BEST_W = 20;

  // Running best starts above any reachable distance sum
  localparam logic [BEST_W-1:0] BEST_INIT = 20'd999999;

  // Reset value of the entry count register
  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

  // Item kind codes carried in tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One 24-bit palette color, red in the top byte
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Squared channel differences of one entry against the query
  typedef struct packed {
    logic [SQ_W-1:0] red;
    logic [SQ_W-1:0] green;
    logic [SQ_W-1:0] blue;
  } sq_t;

endpackage

// ----- hdl/npcs_palette_mem.sv -----
// Palette storage: one write port, one read port with registered read data.
module npcs_palette_mem #(
  parameter int DEPTH = 256,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  npcs_pkg::rgb_t     wr_data,
  input  logic [IDX_W-1:0]   rd_addr,
  output npcs_pkg::rgb_t     rd_data
);

  npcs_pkg::rgb_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/npcs_dist.sv -----
// Distance stage: squared red, green and blue differences, registered.
module npcs_dist #(
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [IDX_W-1:0]   in_idx,
  input  npcs_pkg::rgb_t     entry,
  input  npcs_pkg::rgb_t     query,
  output logic               sq_vld_r,
  output logic [IDX_W-1:0]   sq_idx_r,
  output npcs_pkg::sq_t      sq_r
);

  logic [npcs_pkg::COLOR_W-1:0] d_red;
  logic [npcs_pkg::COLOR_W-1:0] d_green;
  logic [npcs_pkg::COLOR_W-1:0] d_blue;
  npcs_pkg::sq_t                sq_nxt;

  // Absolute differences
  always_comb begin
    d_red   = (entry.red > query.red) ? entry.red - query.red : query.red - entry.red;
    d_green = (entry.green > query.green) ? entry.green - query.green
                                          : query.green - entry.green;
    d_blue  = (entry.blue > query.blue) ? entry.blue - query.blue : query.blue - entry.blue;
  end

  // Three 8x8 squares
  always_comb begin
    sq_nxt.red   = npcs_pkg::SQ_W'(d_red) * npcs_pkg::SQ_W'(d_red);
    sq_nxt.green = npcs_pkg::SQ_W'(d_green) * npcs_pkg::SQ_W'(d_green);
    sq_nxt.blue  = npcs_pkg::SQ_W'(d_blue) * npcs_pkg::SQ_W'(d_blue);
  end

  // Valid tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= in_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sq_idx_r <= in_idx;
    sq_r     <= sq_nxt;
  end

endmodule

// ----- hdl/nearest_palette_color_search_core.sv -----
// Top level: stream ports, scan sequencer, best-match tracking and result register.
//
// Nearest palette color search. Load words (tuser 0) write one RGB entry into the
// palette; loads with a slot at or above PALETTE_DEPTH are dropped.
// Query words (tuser 1) scan entries 0 to min(color_count, PALETTE_DEPTH)-1 and
// return the index of the first entry with the smallest squared RGB distance. A
// query occupies the block for the scan: one palette read per cycle on the memory's
// single read port, then a short drain of the read, square and compare stages. No
// input word is taken during a scan. A finished result waits in the output
// register, so loads and the next query are taken while it is pending. Entries
// must be loaded before a query reads them; color_count must be written only while
// the block is idle, which the block itself does not enforce.
module nearest_palette_color_search_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic        in_tuser,   // kind: 0 load, 1 query
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // color_index[7:0]
  // Configuration
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata   // color_count
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int LIM_W = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [LIM_W-1:0]                addr_r, addr_nxt;
  logic [LIM_W-1:0]                limit_r, limit_nxt;
  npcs_pkg::rgb_t                  query_r, query_nxt;
  logic [IDX_W-1:0]                best_idx_r, best_idx_nxt;
  logic [npcs_pkg::BEST_W-1:0]     best_sum_r, best_sum_nxt;
  logic [npcs_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [npcs_pkg::ENTRY_W-1:0]    out_idx_r, out_idx_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]                rd_idx_r, rd_idx_nxt;

  logic                            in_acc;
  logic                            is_query;
  logic [npcs_pkg::ENTRY_W-1:0]    in_slot;
  npcs_pkg::rgb_t                  in_color;
  logic                            mem_we;
  npcs_pkg::rgb_t                  rd_data;
  logic                            issue;
  logic                            scan_done;
  logic                            out_free;
  logic [LIM_W-1:0]                query_limit;

  logic                            sq_vld;
  logic [IDX_W-1:0]                sq_idx;
  npcs_pkg::sq_t                   sq;
  logic [npcs_pkg::SUM_W-1:0]      sum;
  logic                            better;

  // Unpack the input word
  assign in_slot        = in_tdata[7:0];
  assign in_color.red   = in_tdata[15:8];
  assign in_color.green = in_tdata[23:16];
  assign in_color.blue  = in_tdata[31:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_query  = (in_tuser == npcs_pkg::KIND_QUERY);

  // Loads into slots beyond the palette are dropped
  assign mem_we = in_acc && (in_tuser == npcs_pkg::KIND_LOAD) &&
                  ({1'b0, in_slot} < (npcs_pkg::ENTRY_W + 1)'(PALETTE_DEPTH));

  // Entries scanned, saturated at the palette depth
  assign query_limit = (count_r > npcs_pkg::CNT_W'(PALETTE_DEPTH)) ?
                       LIM_W'(PALETTE_DEPTH) : count_r[LIM_W-1:0];

  assign issue     = (state_r == ST_SCAN) && (addr_r != limit_r);
  assign scan_done = (state_r == ST_SCAN) && (addr_r == limit_r) && !rd_vld_r && !sq_vld;
  assign out_free  = !out_vld_r || out_tready;

  npcs_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_slot[IDX_W-1:0]),
    .wr_data (in_color),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  npcs_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .in_idx   (rd_idx_r),
    .entry    (rd_data),
    .query    (query_r),
    .sq_vld_r (sq_vld),
    .sq_idx_r (sq_idx),
    .sq_r     (sq)
  );

  // Distance sum and strict compare keeps the lowest index on ties
  assign sum    = npcs_pkg::SUM_W'(sq.red) + npcs_pkg::SUM_W'(sq.green) +
                  npcs_pkg::SUM_W'(sq.blue);
  assign better = npcs_pkg::BEST_W'(sum) < best_sum_r;

  // Sequencer and datapath next values
  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    limit_nxt    = limit_r;
    query_nxt    = query_r;
    best_idx_nxt = best_idx_r;
    best_sum_nxt = best_sum_r;
    count_nxt    = cfg_we ? cfg_wdata : count_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_idx_nxt  = out_idx_r;
    rd_vld_nxt   = issue;
    rd_idx_nxt   = addr_r[IDX_W-1:0];

    if (sq_vld && better) begin
      best_idx_nxt = sq_idx;
      best_sum_nxt = npcs_pkg::BEST_W'(sum);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt    = ST_SCAN;
          addr_nxt     = '0;
          limit_nxt    = query_limit;
          query_nxt    = in_color;
          best_idx_nxt = '0;
          best_sum_nxt = npcs_pkg::BEST_INIT;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + LIM_W'(1);
        end
        if (scan_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_idx_nxt = npcs_pkg::ENTRY_W'(best_idx_r);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= npcs_pkg::COUNT_RESET;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    limit_r    <= limit_nxt;
    query_r    <= query_nxt;
    best_idx_r <= best_idx_nxt;
    best_sum_r <= best_sum_nxt;
    out_idx_r  <= out_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_idx_r;

`ifndef NO_ASSERTIONS
  // Scan address never runs past the entry limit
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (addr_r <= limit_r))
    else $error("scan address beyond limit");

  // Pipeline is empty whenever the block is not scanning
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (!rd_vld_r && !sq_vld))
    else $error("scan pipeline busy outside a scan");

  // A finished scan over entries picks an index inside the scanned range
  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HOLD) && (limit_r != '0)) |-> (LIM_W'(best_idx_r) < limit_r))
    else $error("best index outside scanned range");

  // Leaving the hold state always loads the result register
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HOLD) && out_free) |=> out_vld_r)
    else $error("result not posted");
`endif

endmodule

// ----- sim/npcs_checker.sv -----
`timescale 1ns / 1ps
// Palette search checker: shadows palette and count, predicts each nearest index, compares.
module npcs_checker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output int          mismatch_count,
  output int          pending_count
);

  // Running best starts above the largest possible distance (3 * 255^2)
  localparam int unsigned DIST_START = 999999;

  npcs_pkg::rgb_t             palette_copy [PALETTE_DEPTH];
  logic [npcs_pkg::CNT_W-1:0] entry_count;
  logic [7:0]                 index_queue [$];

  function automatic int unsigned sq_gap(logic [7:0] a, logic [7:0] b);
    int unsigned d;
    d = (a > b) ? 32'(a - b) : 32'(b - a);
    return d * d;
  endfunction

  // First entry with the smallest squared RGB distance; count saturates at depth
  function automatic logic [7:0] nearest_entry(npcs_pkg::rgb_t q);
    int unsigned span;
    int unsigned gap_sum;
    int unsigned best_dist;
    logic [7:0]  best_slot;
    span      = (int'(entry_count) > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(entry_count);
    best_slot = '0;
    best_dist = DIST_START;
    for (int i = 0; i < span; i++) begin
      gap_sum = sq_gap(palette_copy[i].red, q.red) + sq_gap(palette_copy[i].green, q.green)
              + sq_gap(palette_copy[i].blue, q.blue);
      if (gap_sum < best_dist) begin
        best_dist = gap_sum;
        best_slot = i[7:0];
      end
    end
    return best_slot;
  endfunction

  always @(posedge clk) begin : watch
    logic [npcs_pkg::ENTRY_W-1:0] slot;
    npcs_pkg::rgb_t               color;
    logic [7:0]                   want;
    if (!rst_n) begin
      entry_count    = npcs_pkg::COUNT_RESET;
      mismatch_count = 0;
      index_queue.delete();
    end else begin
      if (cfg_we)
        entry_count = cfg_wdata;

      // Result word: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (index_queue.size() == 0) begin
          $error("color_index: no result expected, actual %0d", out_tdata);
          mismatch_count++;
        end else begin
          want = index_queue.pop_front();
          if (out_tdata !== want) begin
            $error("color_index: expected %0d, actual %0d", want, out_tdata);
            mismatch_count++;
          end
        end
      end

      // Input word: load updates the palette, query queues a prediction
      if (in_tvalid && in_tready) begin
        slot        = in_tdata[7:0];
        color.red   = in_tdata[15:8];
        color.green = in_tdata[23:16];
        color.blue  = in_tdata[31:24];
        if (in_tuser == npcs_pkg::KIND_LOAD) begin
          if (slot < PALETTE_DEPTH)
            palette_copy[slot] = color;
        end else begin
          index_queue.push_back(nearest_entry(color));
        end
      end
    end
    pending_count = index_queue.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the palette search core: stimulus, throttling, watchdog and verdict.
module tb_top;

  localparam int PALETTE_DEPTH = 256;
  localparam int DRAIN_CYCLES  = 270;   // longest scan plus pipeline drain
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 32;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // color_index[7:0]
  logic        cfg_we;
  logic [8:0]  cfg_wdata;

  int             mismatch_count;
  int             pending_count;
  int             send_idle_pct = 25;
  int             recv_idle_pct = 73;
  logic           hold_req = 1'b0;
  int             count_now;
  int             loads_sent;
  int             queries_sent;
  int             settings_used;
  npcs_pkg::rgb_t shade [PALETTE_DEPTH];   // palette as loaded, for picking query colors
  int             phase_counts [PHASES];

  nearest_palette_color_search_core #(.PALETTE_DEPTH(PALETTE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  npcs_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random color with channels biased toward 0, mid and full scale for ties
  function automatic npcs_pkg::rgb_t random_color();
    logic [23:0] c;
    c = 24'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(5))
        0: c[k*8 +: 8] = 8'h00;
        1: c[k*8 +: 8] = 8'hff;
        2: c[k*8 +: 8] = 8'h80;
        default: ;
      endcase
    end
    return c;
  endfunction

  // One input word; entered and left at a falling edge, valid left high
  task automatic send_word(input logic kind, input logic [7:0] slot,
                           input npcs_pkg::rgb_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {c.blue, c.green, c.red, slot};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind == npcs_pkg::KIND_LOAD) begin
      shade[slot] = c;
      loads_sent++;
    end else begin
      queries_sent++;
    end
  endtask

  // Block drained: no result owed, and any trailing scan finished
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_count(input int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[8:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_now = value;
    settings_used++;
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 25; recv_idle_pct = 73; end
      1: begin send_idle_pct = 73; recv_idle_pct = 25; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Result side: random backpressure, or one long hold-off on request
  initial begin : result_sink
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any word moving on either stream
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int             span;
    logic [7:0]     slot;
    npcs_pkg::rgb_t color;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = npcs_pkg::KIND_LOAD;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    count_now     = int'(npcs_pkg::COUNT_RESET);
    loads_sent    = 0;
    queries_sent  = 0;
    settings_used = 0;
    phase_counts  = '{256, 7, 511, 33, 2, 300, 16, 129, 1, 64, 5, 256};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    set_mode(0);

    // Single-entry palette
    set_count(1);
    send_word(npcs_pkg::KIND_LOAD, 8'd0, 24'h000000);
    send_word(npcs_pkg::KIND_QUERY, 8'hff, 24'hffffff);
    send_word(npcs_pkg::KIND_QUERY, 8'h00, 24'h000000);

    // Four entries with a duplicate pair: ties go to the lower slot
    set_count(4);
    send_word(npcs_pkg::KIND_LOAD, 8'd1, 24'hffffff);
    send_word(npcs_pkg::KIND_LOAD, 8'd2, 24'h808080);
    send_word(npcs_pkg::KIND_LOAD, 8'd3, 24'h808080);
    send_word(npcs_pkg::KIND_LOAD, 8'd255, 24'hff00ff);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'h808080);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'hffffff);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'h7f8081);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'hff00ff);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'h00ff00);
    send_word(npcs_pkg::KIND_QUERY, 8'd0, 24'h000001);

    // Zero count scans nothing and answers slot zero
    set_count(0);
    send_word(npcs_pkg::KIND_QUERY, 8'h5a, 24'h123456);
    send_word(npcs_pkg::KIND_QUERY, 8'ha5, 24'hffffff);

    // Fill the whole palette so any count is legal from here on
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_word(npcs_pkg::KIND_LOAD, i[7:0], random_color());

    // Random phases: one count each, throttling modes in turn
    for (int p = 0; p < PHASES; p++) begin
      set_mode(p / 4);
      set_count(phase_counts[p]);
      if (p == 5)
        hold_req = 1'b1;
      span = (count_now > PALETTE_DEPTH) ? PALETTE_DEPTH : count_now;
      repeat (PHASE_WORDS) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(99) < 70)
            slot = 8'($urandom_range(span - 1));
          else
            slot = 8'($urandom_range(PALETTE_DEPTH - 1));
          send_word(npcs_pkg::KIND_LOAD, slot, random_color());
        end else begin
          case ($urandom_range(9))
            0, 1, 2: color = shade[$urandom_range(span - 1)];
            3:       color = $urandom_range(1) ? 24'hffffff : 24'h000000;
            default: color = random_color();
          endcase
          send_word(npcs_pkg::KIND_QUERY, 8'($urandom_range(255)), color);
        end
      end
    end

    wait_idle();
    $display("Covered %0d palette loads and %0d queries under %0d count settings (0 to 511)",
             loads_sent, queries_sent, settings_used);
    $display("Both streams throttled in turn, plus one %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/npcs_pkg.sv
hdl/npcs_palette_mem.sv
hdl/npcs_dist.sv
hdl/nearest_palette_color_search_core.sv
sim/npcs_checker.sv
sim/tb_top.sv
